// ===== hw/rtl/gcsa_pkg.sv =====
// Shared types and constants for the Gaussian chi-square accumulator.
// Used by the controller, the datapath and the top level; no dependencies.
package gcsa_pkg;

    localparam int XPOS_W    = 16;
    localparam int COUNT_W   = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int Q168_W    = 24;
    localparam int MODEL_W   = 32;
    localparam int CHI_W     = 48;
    localparam int TALLY_W   = 16;
    localparam int DD_W      = 34;
    localparam int DIV_NUM_W = 68;
    localparam int DIV_DEN_W = 53;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 104;

    localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd3;

    localparam logic [Q168_W-1:0] WIDTH_RESET = 24'd256;
    localparam logic [CHI_W-1:0]  CHI_MAX     = {CHI_W{1'b1}};

    typedef struct packed {
        logic load_in;
        logic square;
        logic idx_start;
        logic lookup;
        logic product;
        logic model;
        logic diff;
        logic mul_lo;
        logic mul_hi;
        logic term_start;
        logic update;
        logic load_out;
    } gcsa_cmd_t;

    typedef struct packed {
        logic div_done;
        logic zero_count;
    } gcsa_status_t;

endpackage

// ===== hw/rtl/gaussian_chi_square_accumulator.sv =====
// Gaussian chi-square accumulator, top level. Depends on gcsa_pkg, gcsa_ctrl, gcsa_datapath.
// One word at a time: the bit-serial divider is used twice for a nonzero count and once
// for a zero count, which skips the chi-square term.
// The next word is accepted the cycle after the result enters the output register; the
// result enters it only when the output register is free or being read by the result side.
// Reset (synchronous, active low) restores the fit registers to their defaults and
// clears the running sum, point tally and flags.
module gaussian_chi_square_accumulator
    import gcsa_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 256,
    parameter int SUM_WIDTH       = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // channel_pos[15:0], channel_count[39:16]
    input  logic                  s_tlast,   // last_point
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // model_value[31:0], chi_square[79:32], points_used[95:80],
    // zero_count_seen[96], sum_saturated[97], zero fill[103:98]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast    // set_done
);

    gcsa_cmd_t    cmd;
    gcsa_status_t status;

    gcsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gcsa_datapath #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
        .SUM_WIDTH       (SUM_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== hw/rtl/gcsa_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on gcsa_pkg for the operand widths.
module gcsa_div
    import gcsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] numer,
    input  logic [DIV_DEN_W-1:0] denom,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg, q_reg[DIV_NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(DIV_NUM_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end else if (cnt_reg != '0) begin
            // The numerator shifts out at the top while quotient bits enter below.
            rem_reg <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DEN_W-1:0];
            q_reg   <= {q_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== hw/rtl/gcsa_datapath.sv =====
// Datapath: configuration registers, exp table, multipliers, shared divider,
// accumulator and output word. Depends on gcsa_pkg and gcsa_div.
module gcsa_datapath
    import gcsa_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 256,
    parameter int SUM_WIDTH       = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic [IN_DATA_W-1:0]   in_data,
    input  logic                   in_last,
    input  gcsa_cmd_t              cmd,
    output gcsa_status_t           status,
    output logic [OUT_DATA_W-1:0]  out_data,
    output logic                   out_last
);

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

    typedef logic [16:0] exp_tab_t [EXP_TABLE_DEPTH];

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] hq;
        logic [63:0] term;
        logic [63:0] mul;
        logic [63:0] e;
        hq   = (64'd16 << 31) / EXP_TABLE_DEPTH;
        term = 64'd1 << 31;
        mul  = 64'd1 << 31;
        e    = 64'd1 << 31;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * hq) >> 31) / 64'(k);
            if (k % 2 == 1) mul = mul - term;
            else mul = mul + term;
        end
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            tab[i] = 17'((e + 64'd16384) >> 15);
            e      = (e * mul) >> 31;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

    // Configuration registers.
    logic signed [CFG_W-1:0]  baseline_reg;
    logic signed [CFG_W-1:0]  height_reg;
    logic        [Q168_W-1:0] center_reg;
    logic        [Q168_W-1:0] width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= '0;
            height_reg   <= '0;
            center_reg   <= '0;
            width_reg    <= WIDTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BASELINE: baseline_reg <= cfg_wdata;
                REG_HEIGHT:   height_reg   <= cfg_wdata;
                REG_CENTER:   center_reg   <= cfg_wdata[Q168_W-1:0];
                REG_WIDTH:    width_reg    <= cfg_wdata[Q168_W-1:0];
                default:      ;
            endcase
        end
    end

    // Per-word working registers.
    logic [XPOS_W-1:0]      x_reg;
    logic [COUNT_W-1:0]     y_reg;
    logic                   last_reg;
    logic [47:0]            dsq_reg;
    logic [47:0]            ssq_reg;
    logic [16:0]            e_reg;
    logic signed [49:0]     prod_reg;
    logic signed [MODEL_W-1:0] model_reg;
    logic [DD_W-1:0]        dd_reg;
    logic [50:0]            pp_reg;
    logic [DIV_NUM_W-1:0]   ddsq_reg;

    logic [Q168_W-1:0]      xq;
    logic [Q168_W-1:0]      d;
    logic [Q168_W-1:0]      s;
    logic signed [49:0]     rnd;
    logic signed [34:0]     msum;
    logic signed [34:0]     diff;
    logic                   in_range;
    logic [50:0]            pp_hi;

    logic                   div_start;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_DEN_W-1:0]   div_den;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   div_quot;

    assign xq = {x_reg, 8'd0};
    assign d  = (xq >= center_reg) ? xq - center_reg : center_reg - xq;
    assign s  = (width_reg == '0) ? Q168_W'(1) : width_reg;

    assign rnd  = (prod_reg + 50'sd32768) >>> 16;
    assign msum = 35'(rnd) + 35'(baseline_reg);
    assign diff = $signed({3'b0, y_reg, 8'd0}) - 35'(model_reg);
    assign in_range = div_quot < DIV_NUM_W'(EXP_TABLE_DEPTH);
    assign pp_hi = dd_reg * dd_reg[33:17];

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg    <= in_data[XPOS_W-1:0];
            y_reg    <= in_data[XPOS_W +: COUNT_W];
            last_reg <= in_last;
        end
        if (cmd.square) begin
            dsq_reg <= d * d;
            ssq_reg <= s * s;
        end
        if (cmd.lookup) begin
            e_reg <= in_range ? EXP_TAB[div_quot[IDX_W-1:0]] : 17'd0;
        end
        if (cmd.product) begin
            prod_reg <= height_reg * $signed({1'b0, e_reg});
        end
        if (cmd.model) begin
            if (msum > 35'sd2147483647) model_reg <= 32'sh7FFFFFFF;
            else if (msum < -35'sd2147483648) model_reg <= 32'sh80000000;
            else model_reg <= msum[MODEL_W-1:0];
        end
        if (cmd.diff) begin
            dd_reg <= diff[34] ? DD_W'(-diff) : DD_W'(diff);
        end
        // The square of the difference is built from two half-width products.
        if (cmd.mul_lo) begin
            pp_reg <= dd_reg * dd_reg[16:0];
        end
        if (cmd.mul_hi) begin
            ddsq_reg <= DIV_NUM_W'(pp_reg) + (DIV_NUM_W'(pp_hi) << 17);
        end
    end

    assign div_start = cmd.idx_start | cmd.term_start;
    always_comb begin
        if (cmd.idx_start) begin
            div_num = DIV_NUM_W'(dsq_reg) * DIV_NUM_W'(EXP_TABLE_DEPTH)
                      + (DIV_NUM_W'(ssq_reg) << 4);
            div_den = DIV_DEN_W'(ssq_reg) << 5;
        end else begin
            div_num = ddsq_reg;
            div_den = DIV_DEN_W'(y_reg);
        end
    end

    gcsa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Accumulator state.
    logic [SUM_WIDTH-1:0] sum_reg;
    logic [TALLY_W-1:0]   tally_reg;
    logic                 zero_reg;
    logic                 clip_reg;
    logic [SUM_WIDTH-1:0] headroom;
    logic                 over;
    logic [63:0]          sh64;
    logic [CHI_W-1:0]     chi;

    assign headroom = {SUM_WIDTH{1'b1}} - sum_reg;
    assign over     = div_quot > DIV_NUM_W'(headroom);
    assign sh64     = 64'(sum_reg) >> 2;
    assign chi      = (sh64 > 64'(CHI_MAX)) ? CHI_MAX : sh64[CHI_W-1:0];

    logic [MODEL_W-1:0]  o_model_reg;
    logic [CHI_W-1:0]    o_chi_reg;
    logic [TALLY_W-1:0]  o_tally_reg;
    logic                o_zero_reg;
    logic                o_clip_reg;
    logic                o_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            tally_reg <= '0;
            zero_reg  <= 1'b0;
            clip_reg  <= 1'b0;
        end else if (cmd.update) begin
            if (y_reg == '0) begin
                zero_reg <= 1'b1;
            end else begin
                if (over) begin
                    sum_reg  <= {SUM_WIDTH{1'b1}};
                    clip_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_reg + div_quot[SUM_WIDTH-1:0];
                end
                if (tally_reg != {TALLY_W{1'b1}}) tally_reg <= tally_reg + TALLY_W'(1);
            end
        end else if (cmd.load_out && last_reg) begin
            sum_reg   <= '0;
            tally_reg <= '0;
            zero_reg  <= 1'b0;
            clip_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            o_model_reg <= model_reg;
            o_chi_reg   <= last_reg ? chi : '0;
            o_tally_reg <= tally_reg;
            o_zero_reg  <= zero_reg;
            o_clip_reg  <= clip_reg;
            o_last_reg  <= last_reg;
        end
    end

    assign out_data = {6'd0, o_clip_reg, o_zero_reg, o_tally_reg, o_chi_reg, o_model_reg};
    assign out_last = o_last_reg;

    assign status.div_done   = div_done;
    assign status.zero_count = (y_reg == '0);

endmodule

// ===== hw/rtl/gcsa_ctrl.sv =====
// Controller: sequences one word through the datapath and owns the handshakes.
// Depends on gcsa_pkg for the command and status structs.
module gcsa_ctrl
    import gcsa_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  gcsa_status_t  status,
    output gcsa_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQUARE, ST_IDX_GO, ST_IDX_WAIT, ST_LOOKUP, ST_PRODUCT,
        ST_MODEL, ST_DIFF, ST_MUL_LO, ST_MUL_HI, ST_TERM_GO, ST_TERM_WAIT,
        ST_UPDATE, ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && out_free) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:      if (s_tvalid) state_reg <= ST_SQUARE;
                ST_SQUARE:    state_reg <= ST_IDX_GO;
                ST_IDX_GO:    state_reg <= ST_IDX_WAIT;
                ST_IDX_WAIT:  if (status.div_done) state_reg <= ST_LOOKUP;
                ST_LOOKUP:    state_reg <= ST_PRODUCT;
                ST_PRODUCT:   state_reg <= ST_MODEL;
                // A zero count skips the chi-square term entirely.
                ST_MODEL:     state_reg <= status.zero_count ? ST_UPDATE : ST_DIFF;
                ST_DIFF:      state_reg <= ST_MUL_LO;
                ST_MUL_LO:    state_reg <= ST_MUL_HI;
                ST_MUL_HI:    state_reg <= ST_TERM_GO;
                ST_TERM_GO:   state_reg <= ST_TERM_WAIT;
                ST_TERM_WAIT: if (status.div_done) state_reg <= ST_UPDATE;
                ST_UPDATE:    state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.load_in    = (state_reg == ST_IDLE) && s_tvalid;
        cmd.square     = (state_reg == ST_SQUARE);
        cmd.idx_start  = (state_reg == ST_IDX_GO);
        cmd.lookup     = (state_reg == ST_LOOKUP);
        cmd.product    = (state_reg == ST_PRODUCT);
        cmd.model      = (state_reg == ST_MODEL);
        cmd.diff       = (state_reg == ST_DIFF);
        cmd.mul_lo     = (state_reg == ST_MUL_LO);
        cmd.mul_hi     = (state_reg == ST_MUL_HI);
        cmd.term_start = (state_reg == ST_TERM_GO);
        cmd.update     = (state_reg == ST_UPDATE);
        cmd.load_out   = (state_reg == ST_OUT) && out_free;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for the Gaussian chi-square accumulator.
// Depends on gcsa_pkg and gaussian_chi_square_accumulator; predicts every result word.
module tb_top;
    import gcsa_pkg::*;

    localparam int TAB_DEPTH = 256;
    localparam int SUMW      = 48;
    localparam longint unsigned SUM_TOP = (64'd1 << SUMW) - 1;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [15:0] pos;
        logic [23:0] cnt;
        logic        last;
    } point_t;

    typedef struct packed {
        logic [31:0] model;
        logic [47:0] chi;
        logic [15:0] used;
        logic        zero_seen;
        logic        clipped;
        logic        done;
    } fit_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;

    gaussian_chi_square_accumulator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    logic [31:0] exp_q16 [TAB_DEPTH];
    logic [31:0] fit_base, fit_height;
    logic [23:0] fit_center, fit_sigma;
    longint unsigned acc_sum;
    int unsigned acc_tally;
    bit acc_zero, acc_clip;

    point_t pending_points[$];
    fit_result_t expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int sets_closed = 0;
    bit hold_sender = 1'b0;
    longint cycle_count = 0;

    function automatic void build_exp_table();
        longint unsigned hq, term, mul, e;
        hq = (64'd16 << 31) / TAB_DEPTH;
        term = 64'd1 << 31;
        mul = 64'd1 << 31;
        e = 64'd1 << 31;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * hq) >> 31) / k;
            if (k % 2) mul -= term; else mul += term;
        end
        for (int i = 0; i < TAB_DEPTH; i++) begin
            exp_q16[i] = 32'((e + (64'd1 << 14)) >> 15);
            e = (e * mul) >> 31;
        end
    endfunction

    function automatic void write_fit_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            REG_BASELINE: fit_base = val;
            REG_HEIGHT:   fit_height = val;
            REG_CENTER:   fit_center = val[23:0];
            REG_WIDTH:    fit_sigma = val[23:0];
            default: ;
        endcase
    endfunction

    function automatic fit_result_t predict_fit_point(point_t p);
        fit_result_t r;
        longint unsigned xq, c, s, d, idx, e, dd, q, rem, t, y, chi;
        longint signed prod, model, diff;
        bit over;
        y = p.cnt;
        xq = longint'(p.pos) << 8;
        c = fit_center;
        s = (fit_sigma == 0) ? 1 : fit_sigma;
        d = (xq >= c) ? xq - c : c - xq;
        // d^2*256 fits in 64 bits since d < 2^24.
        idx = (d * d * TAB_DEPTH + 16 * s * s) / (32 * s * s);
        e = (idx < TAB_DEPTH) ? exp_q16[idx] : 0;
        prod = longint'(signed'(fit_height)) * longint'(e);
        model = (prod + (64'sd1 << 15)) >>> 16;
        model += longint'(signed'(fit_base));
        if (model > 64'sd2147483647) model = 64'sd2147483647;
        if (model < -64'sd2147483648) model = -64'sd2147483648;
        if (y == 0) begin
            acc_zero = 1'b1;
        end else begin
            diff = longint'(y << 8) - model;
            dd = (diff < 0) ? -diff : diff;
            q = dd / y;
            rem = dd % y;
            over = 1'b0;
            t = 0;
            if (q != 0 && dd > SUM_TOP / q) over = 1'b1;
            else begin
                t = q * dd + (rem * dd) / y;
                if (t > SUM_TOP - acc_sum) over = 1'b1;
            end
            if (over) begin
                acc_sum = SUM_TOP;
                acc_clip = 1'b1;
            end else begin
                acc_sum += t;
            end
            if (acc_tally < 16'hFFFF) acc_tally++;
        end
        chi = p.last ? (acc_sum >> 2) : 0;
        r.model = model[31:0];
        r.chi = chi[47:0];
        r.used = acc_tally[15:0];
        r.zero_seen = acc_zero;
        r.clipped = acc_clip;
        r.done = p.last;
        if (p.last) begin
            acc_sum = 0;
            acc_tally = 0;
            acc_zero = 1'b0;
            acc_clip = 1'b0;
        end
        return r;
    endfunction

    // Driver: bursts of words with random gaps between them.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            // The accepted word leaves the queue first, so the front is always the next one.
            if (s_tvalid && s_tready) void'(pending_points.pop_front());
            if (s_tvalid && !s_tready) begin
                // keep presenting the same word
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_points.size() > 0 && !hold_sender) begin
                point_t p;
                p = pending_points[0];
                s_tvalid <= 1'b1;
                s_tdata <= {p.cnt, p.pos};
                s_tlast <= p.last;
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Predict on acceptance so register writes between phases line up.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_results = {expected_results,
                                predict_fit_point(point_t'({s_tdata[15:0],
                                                            s_tdata[39:16], s_tlast}))};
    end

    // Receiver stall pattern and monitor.
    int stall_phase = 0;
    always @(posedge aclk) begin
        fit_result_t got, want;
        if (aresetn) begin
            stall_phase <= (stall_phase + 1) % 700;
            if (stall_phase < 200) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 2) != 0) && ($urandom_range(0, 60) != 0 ||
                             m_tready);
            if (m_tvalid && m_tready) begin
                got.model = m_tdata[31:0];
                got.chi = m_tdata[79:32];
                got.used = m_tdata[95:80];
                got.zero_seen = m_tdata[96];
                got.clipped = m_tdata[97];
                got.done = m_tlast;
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result word with no expectation: %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.done) sets_closed++;
                    if (got.model !== want.model) begin
                        $error("model_value exp %h got %h", want.model, got.model); errors++;
                    end
                    if (got.chi !== want.chi) begin
                        $error("chi_square exp %h got %h", want.chi, got.chi); errors++;
                    end
                    if (got.used !== want.used) begin
                        $error("points_used exp %0d got %0d", want.used, got.used); errors++;
                    end
                    if (got.zero_seen !== want.zero_seen) begin
                        $error("zero_count_seen exp %b got %b", want.zero_seen,
                               got.zero_seen); errors++;
                    end
                    if (got.clipped !== want.clipped) begin
                        $error("sum_saturated exp %b got %b", want.clipped, got.clipped);
                        errors++;
                    end
                    if (got.done !== want.done) begin
                        $error("set_done exp %b got %b", want.done, got.done); errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_points.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic program_fit(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        write_fit_reg(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void queue_point(int pos, int cnt, bit last);
        point_t p;
        p.pos = pos[15:0];
        p.cnt = cnt[23:0];
        p.last = last;
        pending_points = {pending_points, p};
    endfunction

    // A set of points mostly spread around the centroid, with random counts including zero and near-full-scale ones.
    function automatic void queue_random_set(int npts);
        int center_ch;
        int sig;
        center_ch = fit_center >> 8;
        sig = (fit_sigma >> 8) + 1;
        for (int i = 0; i < npts; i++) begin
            int pos, cnt;
            case ($urandom_range(0, 9))
                0: pos = $urandom_range(0, 65535);
                default: pos = center_ch + $urandom_range(0, 8 * sig) - 4 * sig;
            endcase
            case ($urandom_range(0, 9))
                0: cnt = 0;
                1: cnt = $urandom_range(0, 24'hFFFFFF);
                2: cnt = 24'hFFFFFF - $urandom_range(0, 3);
                default: cnt = $urandom_range(1, 5000);
            endcase
            queue_point(pos, cnt, i == npts - 1);
        end
    endfunction

    initial begin
        int sent;
        build_exp_table();
        fit_base = 0; fit_height = 0; fit_center = 0; fit_sigma = WIDTH_RESET;
        acc_sum = 0; acc_tally = 0; acc_zero = 0; acc_clip = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset registers, field extremes, zero count, last point.
        queue_point(0, 0, 0);
        queue_point(65535, 16777215, 0);
        queue_point(1, 1, 1);
        queue_point(0, 0, 1);
        wait_drained();
        program_fit(REG_BASELINE, 32'h0000_6400);
        program_fit(REG_HEIGHT, 32'h0003_E800);
        program_fit(REG_CENTER, 32'h0000_8000);
        program_fit(REG_WIDTH, 32'h0000_0400);
        for (int i = 120; i < 136; i++) queue_point(i, 1000 + i, i == 135);
        wait_drained();
        // Extreme registers drive the model to its largest value and the sum into clipping.
        program_fit(REG_BASELINE, 32'h7FFF_FFFF);
        program_fit(REG_HEIGHT, 32'h7FFF_FFFF);
        program_fit(REG_CENTER, 32'h00FF_FFFF);
        program_fit(REG_WIDTH, 32'h0000_0000);
        queue_point(65535, 1, 0);
        queue_point(65535, 1, 0);
        queue_point(0, 8388608, 1);
        wait_drained();
        program_fit(REG_BASELINE, 32'h8000_0000);
        program_fit(REG_HEIGHT, 32'h8000_0000);
        program_fit(REG_CENTER, 32'h0000_0000);
        program_fit(REG_WIDTH, 32'h00FF_FFFF);
        queue_point(0, 1, 0);
        queue_point(40000, 1, 1);
        wait_drained();

        // Random phases, each with its own fit.
        sent = 0;
        while (sent < 1850) begin
            program_fit(REG_BASELINE, ($urandom_range(0, 7) == 0) ? $urandom
                                      : $urandom_range(0, 32'h0002_0000));
            program_fit(REG_HEIGHT, ($urandom_range(0, 7) == 0) ? $urandom
                                    : $urandom_range(0, 32'h0010_0000));
            program_fit(REG_CENTER, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                    : $urandom_range(0, 24'h00_FFFF));
            program_fit(REG_WIDTH, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                   : $urandom_range(64, 24'h00_2000));
            repeat ($urandom_range(3, 8)) begin
                int n;
                n = ($urandom_range(0, 15) == 0) ? 1 : $urandom_range(2, 40);
                if (sent < 1850) begin
                    queue_random_set(n);
                    sent += n;
                end
            end
            // Hold the sender mid-run until the outstanding results drain so the block goes fully idle.
            if (sent > 900 && sent < 1000) begin
                hold_sender = 1'b1;
                while (s_tvalid || expected_results.size() != 0) @(posedge aclk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end

        $display("%0d result words checked across %0d closed sets and many fit settings.",
                 results_seen, sets_closed);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/gcsa_pkg.sv
hw/rtl/gcsa_div.sv
hw/rtl/gcsa_datapath.sv
hw/rtl/gcsa_ctrl.sv
hw/rtl/gaussian_chi_square_accumulator.sv
verif/tb_top.sv
